// ===== design/csf_pkg.sv =====
// shared widths, register indexes, sideband type and saturation helper for the charged shell field block
// no dependencies
package csf_pkg;

    localparam int CW   = 24;  // coordinate width, Q12.12
    localparam int DW   = 25;  // difference width
    localparam int AW   = 24;  // magnitude of a difference
    localparam int SQW  = 48;  // square of a difference
    localparam int D2W  = 50;  // sum of squares
    localparam int XW   = 62;  // sqrt operand, d2 scaled by 2^12
    localparam int RW   = 31;  // root width
    localparam int SRW  = RW + 3;
    localparam int RADW = 23;  // radius width
    localparam int KW   = 32;  // charge and output width
    localparam int NW   = 62;  // divider numerator width
    localparam int DVW  = 31;  // divider divisor width
    localparam int QW   = 44;  // divider quotient width
    localparam int WW   = 33;  // direction weight width
    localparam int UHW  = QW / 2;
    localparam int PPW  = UHW + WW;
    localparam int PW   = QW + WW;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_CHARGE   = 3'd4;

    typedef struct packed {
        logic [AW-1:0] ad_x;
        logic [AW-1:0] ad_y;
        logic [AW-1:0] ad_z;
        logic          neg_x;
        logic          neg_y;
        logic          neg_z;
        logic          in_shell;
        logic          zero;
    } t_side;

    // apply a sign to a magnitude, clamp to the signed 32-bit range
    function automatic logic [KW-1:0] sat32(input logic [QW-1:0] mag, input logic neg);
        logic [QW-1:0] m;
        if (neg) begin
            m = (mag > QW'(64'h8000_0000)) ? QW'(64'h8000_0000) : mag;
            return KW'(QW'(0) - m);
        end
        m = (mag > QW'(64'h7FFF_FFFF)) ? QW'(64'h7FFF_FFFF) : mag;
        return m[KW-1:0];
    endfunction

endpackage

// ===== design/charged_shell_field.sv =====
// Field and potential of a uniformly charged spherical shell, one test point per cycle
// unless stalled. The block accepts a point every cycle while o_stall is low; the depth
// of the pipeline is set by the square root (one stage per root bit) and the dividers
// (one stage per quotient bit). The pipeline freezes as a whole only while a result
// waits in the output register under stall. Configuration is written through a separate
// port that is always ready; depends on csf_pkg and csf_div_pipe.
module charged_shell_field import csf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [KW-1:0]        i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    input  logic signed [CW-1:0] i_point_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [KW-1:0] o_field_x,
    output logic signed [KW-1:0] o_field_y,
    output logic signed [KW-1:0] o_field_z,
    output logic signed [KW-1:0] o_potential,
    output logic                 o_inside_shell,
    output logic                 o_singular
);

    localparam int NV = 3 + (RW + 1) + (QW + 1) + 3;

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [RADW-1:0]      r_radius;
    logic [KW-1:0]        r_charge;
    logic [2*RADW-1:0]    r_rr;

    logic          en;
    logic [NV-1:0] r_vld;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_vld[NV-1] || !i_stall;
    assign o_stall     = !en;
    assign o_valid     = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= '0;
            r_charge <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_cx     <= i_cfg_data[CW-1:0];
                REG_CENTER_Y: r_cy     <= i_cfg_data[CW-1:0];
                REG_CENTER_Z: r_cz     <= i_cfg_data[CW-1:0];
                REG_RADIUS:   r_radius <= i_cfg_data[RADW-1:0];
                REG_CHARGE:   r_charge <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr <= (2*RADW)'(r_radius) * (2*RADW)'(r_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    logic          kneg;
    logic [KW-1:0] kmag;
    assign kneg = r_charge[KW-1];
    assign kmag = kneg ? KW'(KW'(0) - r_charge) : r_charge;

    // differences and their magnitudes
    logic signed [DW-1:0] dx, dy, dz;
    t_side                r_s1_side, r_s2_side, r_s3_side;
    assign dx = DW'(i_point_x) - DW'(r_cx);
    assign dy = DW'(i_point_y) - DW'(r_cy);
    assign dz = DW'(i_point_z) - DW'(r_cz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side.ad_x     <= dx[DW-1] ? AW'(-dx) : AW'(dx);
            r_s1_side.ad_y     <= dy[DW-1] ? AW'(-dy) : AW'(dy);
            r_s1_side.ad_z     <= dz[DW-1] ? AW'(-dz) : AW'(dz);
            r_s1_side.neg_x    <= dx[DW-1];
            r_s1_side.neg_y    <= dy[DW-1];
            r_s1_side.neg_z    <= dz[DW-1];
            r_s1_side.in_shell <= 1'b0;
            r_s1_side.zero     <= 1'b0;
        end
    end

    // squares, then their sum
    logic [SQW-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic [D2W-1:0] r_d2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x    <= SQW'(r_s1_side.ad_x) * SQW'(r_s1_side.ad_x);
            r_sq_y    <= SQW'(r_s1_side.ad_y) * SQW'(r_s1_side.ad_y);
            r_sq_z    <= SQW'(r_s1_side.ad_z) * SQW'(r_s1_side.ad_z);
            r_s2_side <= r_s1_side;
            r_d2      <= D2W'(r_sq_x) + D2W'(r_sq_y) + D2W'(r_sq_z);
            r_s3_side <= r_s2_side;
        end
    end

    // digit-by-digit square root, two operand bits per stage
    logic [XW-1:0]  r_sx    [0:RW];
    logic [SRW-1:0] r_srem  [0:RW];
    logic [RW-1:0]  r_sroot [0:RW];
    t_side          r_sq_side [0:RW];
    t_side          sq_side_in;

    always_comb begin
        sq_side_in          = r_s3_side;
        sq_side_in.in_shell = D2W'(r_d2) < D2W'(r_rr);
        sq_side_in.zero     = r_d2 == '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx[0]      <= {r_d2, 12'b0};
            r_srem[0]    <= '0;
            r_sroot[0]   <= '0;
            r_sq_side[0] <= sq_side_in;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [SRW-1:0] rem2;
        logic [SRW-1:0] trial;
        logic           ge;
        assign rem2  = {r_srem[k][SRW-3:0], r_sx[k][XW-1:XW-2]};
        assign trial = SRW'({r_sroot[k], 2'b01});
        assign ge    = rem2 >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[k+1]    <= ge ? rem2 - trial : rem2;
                r_sroot[k+1]   <= {r_sroot[k][RW-2:0], ge};
                r_sx[k+1]      <= r_sx[k] << 2;
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // divider operands: inside uses the radius, a zero distance gets a dummy divisor
    t_side          sq_out;
    logic [DVW-1:0] den_r, den_u;
    logic [NW-1:0]  num_u, num_x, num_y, num_z;
    assign sq_out = r_sq_side[RW];
    assign den_r  = sq_out.zero ? DVW'(1) : DVW'(r_sroot[RW]);
    assign den_u  = sq_out.in_shell ? DVW'(r_radius) : den_r;
    assign num_u  = sq_out.in_shell ? (NW'(kmag) << 12) : (NW'(kmag) << 18);
    assign num_x  = NW'(sq_out.ad_x) << 38;
    assign num_y  = NW'(sq_out.ad_y) << 38;
    assign num_z  = NW'(sq_out.ad_z) << 38;

    logic [QW-1:0] q_u, q_x, q_y, q_z;
    t_side         r_dv_side [0:QW];

    csf_div_pipe #(.P_NW(NW), .P_DVW(DVW), .P_QW(QW)) u_div_u (
        .i_clk(i_clk), .i_en(en), .i_num(num_u), .i_den(den_u), .o_quo(q_u)
    );
    csf_div_pipe #(.P_NW(NW), .P_DVW(DVW), .P_QW(QW)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(num_x), .i_den(den_r), .o_quo(q_x)
    );
    csf_div_pipe #(.P_NW(NW), .P_DVW(DVW), .P_QW(QW)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(num_y), .i_den(den_r), .o_quo(q_y)
    );
    csf_div_pipe #(.P_NW(NW), .P_DVW(DVW), .P_QW(QW)) u_div_z (
        .i_clk(i_clk), .i_en(en), .i_num(num_z), .i_den(den_r), .o_quo(q_z)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= sq_out;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_dv_side
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    // u times each weight, split in two partial products, then summed
    logic [PPW-1:0] r_pph_x, r_pph_y, r_pph_z, r_ppl_x, r_ppl_y, r_ppl_z;
    logic [QW-1:0]  r_m1_u, r_m2_u;
    t_side          r_m1_side, r_m2_side;
    logic [PW-1:0]  r_prod_x, r_prod_y, r_prod_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pph_x   <= PPW'(q_u[QW-1:UHW]) * PPW'(q_x[WW-1:0]);
            r_pph_y   <= PPW'(q_u[QW-1:UHW]) * PPW'(q_y[WW-1:0]);
            r_pph_z   <= PPW'(q_u[QW-1:UHW]) * PPW'(q_z[WW-1:0]);
            r_ppl_x   <= PPW'(q_u[UHW-1:0]) * PPW'(q_x[WW-1:0]);
            r_ppl_y   <= PPW'(q_u[UHW-1:0]) * PPW'(q_y[WW-1:0]);
            r_ppl_z   <= PPW'(q_u[UHW-1:0]) * PPW'(q_z[WW-1:0]);
            r_m1_u    <= q_u;
            r_m1_side <= r_dv_side[QW];
            r_prod_x  <= (PW'(r_pph_x) << UHW) + PW'(r_ppl_x);
            r_prod_y  <= (PW'(r_pph_y) << UHW) + PW'(r_ppl_y);
            r_prod_z  <= (PW'(r_pph_z) << UHW) + PW'(r_ppl_z);
            r_m2_u    <= r_m1_u;
            r_m2_side <= r_m1_side;
        end
    end

    // product above 64 bits saturates the magnitude
    logic [QW-1:0] mag_x, mag_y, mag_z;
    logic [KW-1:0] sing_val, fld_x, fld_y, fld_z, pot;
    logic          sing;
    assign mag_x = (|r_prod_x[PW-1:64]) ? QW'(64'hFFFF_FFFF) : QW'(r_prod_x[63:32]);
    assign mag_y = (|r_prod_y[PW-1:64]) ? QW'(64'hFFFF_FFFF) : QW'(r_prod_y[63:32]);
    assign mag_z = (|r_prod_z[PW-1:64]) ? QW'(64'hFFFF_FFFF) : QW'(r_prod_z[63:32]);
    assign sing     = r_m2_side.zero && !r_m2_side.in_shell;
    assign sing_val = (kmag == '0) ? '0 : (kneg ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_comb begin
        if (r_m2_side.in_shell) begin
            fld_x = '0;
            fld_y = '0;
            fld_z = '0;
            pot   = sat32(r_m2_u, kneg);
        end else if (sing) begin
            fld_x = sing_val;
            fld_y = sing_val;
            fld_z = sing_val;
            pot   = sing_val;
        end else begin
            fld_x = sat32(mag_x, kneg ^ r_m2_side.neg_x);
            fld_y = sat32(mag_y, kneg ^ r_m2_side.neg_y);
            fld_z = sat32(mag_z, kneg ^ r_m2_side.neg_z);
            pot   = sat32(r_m2_u, kneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_field_x      <= fld_x;
            o_field_y      <= fld_y;
            o_field_z      <= fld_z;
            o_potential    <= pot;
            o_inside_shell <= r_m2_side.in_shell;
            o_singular     <= sing;
        end
    end

endmodule

// ===== design/csf_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on csf_pkg for default widths
module csf_div_pipe import csf_pkg::*; #(
    parameter int P_NW  = NW,
    parameter int P_DVW = DVW,
    parameter int P_QW  = QW
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [P_NW-1:0]  i_num,
    input  logic [P_DVW-1:0] i_den,
    output logic [P_QW-1:0]  o_quo
);

    logic [P_DVW-1:0] r_rem [0:P_QW];
    logic [P_QW-1:0]  r_low [0:P_QW];
    logic [P_DVW-1:0] r_den [0:P_QW];
    logic [P_QW-1:0]  r_quo [0:P_QW];

    // high numerator bits start as the partial remainder, below the divisor by range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= P_DVW'(i_num >> P_QW);
            r_low[0] <= i_num[P_QW-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 0; k < P_QW; k++) begin : g_stage
        logic [P_DVW:0] trial;
        logic           ge;
        assign trial = {r_rem[k], r_low[k][P_QW-1]};
        assign ge    = trial >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? P_DVW'(trial - {1'b0, r_den[k]}) : P_DVW'(trial);
                r_low[k+1] <= r_low[k] << 1;
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][P_QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[P_QW];

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for charged_shell_field: directed and random test points
// under several shell settings, with a scoreboard that predicts field and potential
// depends on csf_pkg and the charged_shell_field design
module testbench import csf_pkg::*; ();

    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct {
        logic signed [KW-1:0] field_x;
        logic signed [KW-1:0] field_y;
        logic signed [KW-1:0] field_z;
        logic signed [KW-1:0] potential;
        logic                 inside_shell;
        logic                 singular;
    } t_field_res;

    class shell_scoreboard;
        logic signed [CW-1:0]   cen_x, cen_y, cen_z;
        logic [RADW-1:0]        radius;
        logic signed [KW-1:0]   charge;
        t_field_res             pending[$];
        int                     errors;

        function new();
            cen_x = '0; cen_y = '0; cen_z = '0; radius = '0; charge = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [KW-1:0] data);
            case (idx)
                REG_CENTER_X: cen_x = data[CW-1:0];
                REG_CENTER_Y: cen_y = data[CW-1:0];
                REG_CENTER_Z: cen_z = data[CW-1:0];
                REG_RADIUS:   radius = data[RADW-1:0];
                REG_CHARGE:   charge = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] root(logic [63:0] x);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [KW-1:0] clamp(logic [63:0] mag, logic neg);
            if (neg) begin
                if (mag > 64'h8000_0000) mag = 64'h8000_0000;
                return KW'(64'd0 - mag);
            end
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            return mag[KW-1:0];
        endfunction

        function void note(logic signed [CW-1:0] px, py, pz);
            longint      d[3];
            logic [63:0] ad[3];
            logic [63:0] d2, rr, kmag, r, u, w, mag;
            logic [127:0] prod;
            logic [KW-1:0] fld[3];
            logic        kneg;
            t_field_res  e;
            d[0] = longint'(px) - longint'(cen_x);
            d[1] = longint'(py) - longint'(cen_y);
            d[2] = longint'(pz) - longint'(cen_z);
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
                ad[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
                d2 = d2 + ad[i] * ad[i];
            end
            rr = 64'(radius) * 64'(radius);
            kneg = charge[KW-1];
            kmag = kneg ? 64'(-longint'(charge)) : 64'(charge);
            if (d2 < rr) begin
                e.field_x = 0; e.field_y = 0; e.field_z = 0;
                e.potential = clamp((kmag << 12) / 64'(radius), kneg);
                e.inside_shell = 1'b1; e.singular = 1'b0;
            end else if (d2 == 0) begin
                e.field_x = (kmag == 0) ? '0 : clamp(64'hFFFF_FFFF, kneg);
                e.field_y = e.field_x; e.field_z = e.field_x; e.potential = e.field_x;
                e.inside_shell = 1'b0; e.singular = 1'b1;
            end else begin
                r = root(d2 << 12);
                u = (kmag << 18) / r;
                for (int i = 0; i < 3; i++) begin
                    w = (ad[i] << 38) / r;
                    prod = 128'(u) * 128'(w);
                    if (w == 0 || u == 0) mag = 0;
                    else if (prod[127:64] != 0) mag = 64'hFFFF_FFFF;
                    else mag = prod[63:0] >> 32;
                    fld[i] = (mag == 0) ? '0 : clamp(mag, kneg != (d[i] < 0));
                end
                e.field_x = fld[0]; e.field_y = fld[1]; e.field_z = fld[2];
                e.potential = (u == 0) ? '0 : clamp(u, kneg);
                e.inside_shell = 1'b0; e.singular = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check(t_field_res got);
            t_field_res e;
            if (pending.size() == 0) begin
                $error("result with no pending test point");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.field_x !== e.field_x) begin
                $error("field_x expected %0d actual %0d", e.field_x, got.field_x); errors++;
            end
            if (got.field_y !== e.field_y) begin
                $error("field_y expected %0d actual %0d", e.field_y, got.field_y); errors++;
            end
            if (got.field_z !== e.field_z) begin
                $error("field_z expected %0d actual %0d", e.field_z, got.field_z); errors++;
            end
            if (got.potential !== e.potential) begin
                $error("potential expected %0d actual %0d", e.potential, got.potential);
                errors++;
            end
            if (got.inside_shell !== e.inside_shell) begin
                $error("inside_shell expected %0d actual %0d", e.inside_shell,
                       got.inside_shell);
                errors++;
            end
            if (got.singular !== e.singular) begin
                $error("singular expected %0d actual %0d", e.singular, got.singular);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index = '0;
    logic [KW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic signed [CW-1:0] i_point_x = '0;
    logic signed [CW-1:0] i_point_y = '0;
    logic signed [CW-1:0] i_point_z = '0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic signed [KW-1:0] o_field_x, o_field_y, o_field_z, o_potential;
    logic                 o_inside_shell, o_singular;

    shell_scoreboard board = new();
    int  stall_mode = 0;
    int  idle_cycles = 0;
    int  cyc = 0;
    localparam int WATCHDOG = 4000;

    charged_shell_field u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // monitor, stall pattern and watchdog
    always @(posedge i_clk) begin
        t_field_res got;
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note(i_point_x, i_point_y, i_point_z);
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
            if (o_valid && !i_stall) begin
                got.field_x = o_field_x; got.field_y = o_field_y;
                got.field_z = o_field_z; got.potential = o_potential;
                got.inside_shell = o_inside_shell; got.singular = o_singular;
                board.check(got);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= (cyc % 23) < 9;
            default: i_stall <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic write_cfg(logic [2:0] idx, logic [KW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_shell(logic [CW-1:0] cx, cy, cz, logic [RADW-1:0] rad,
                             logic [KW-1:0] kq);
        write_cfg(REG_CENTER_X, KW'(cx));
        write_cfg(REG_CENTER_Y, KW'(cy));
        write_cfg(REG_CENTER_Z, KW'(cz));
        write_cfg(REG_RADIUS, KW'(rad));
        write_cfg(REG_CHARGE, kq);
    endtask

    // valid stays high across back-to-back points
    task automatic send_point(logic [CW-1:0] px, py, pz);
        i_valid   <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] near(logic [CW-1:0] c, int span);
        return c + CW'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic random_phase(int count);
        int burst;
        int kind;
        logic [CW-1:0] px, py, pz;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 5);
            case (kind)
                0, 1: begin
                    px = CW'($urandom); py = CW'($urandom); pz = CW'($urandom);
                end
                2: begin
                    px = near(board.cen_x, 64); py = near(board.cen_y, 64);
                    pz = near(board.cen_z, 64);
                end
                3: begin
                    px = board.cen_x; py = board.cen_y; pz = board.cen_z;
                end
                default: begin
                    px = near(board.cen_x, int'(board.radius));
                    py = near(board.cen_y, int'(board.radius) / 2);
                    pz = near(board.cen_z, int'(board.radius) / 2);
                end
            endcase
            send_point(px, py, pz);
            if (--burst == 0) begin
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial begin
        logic [RADW-1:0] rad;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero charge at reset, then point charge at origin
        send_point('0, '0, '0);
        send_point(24'h7FFFFF, 24'h800000, 24'h000001);
        drain();
        set_shell('0, '0, '0, '0, 32'h0001_0000);
        write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        send_point('0, '0, '0);
        send_point(24'h001000, '0, '0);
        send_point('0, 24'hFFF000, '0);
        send_point('0, '0, 24'h000001);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h800000, 24'h800000, 24'h800000);
        drain();
        // shell with extreme charge, on, inside and outside the surface
        set_shell(24'h7FFFFF, 24'h800000, 24'h001000, 23'h002000, 32'h8000_0000);
        send_point(24'h7FFFFF, 24'h800000, 24'h001000);
        send_point(24'h7FFFFF, 24'h800000, 24'h003000);
        send_point(24'h7FFFFF, 24'h800000, 24'h002FFF);
        send_point(24'h800000, 24'h7FFFFF, 24'hFFF000);
        send_point('0, '0, '0);
        drain();
        set_shell(24'h800000, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 32'h7FFF_FFFF);
        send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_point('0, '0, '0);
        send_point(24'h800000, 24'h7FFFFF, 24'h800000);
        drain();
        set_shell('0, '0, '0, 23'h000001, 32'hFFFF_FFFF);
        send_point('0, '0, '0);
        send_point(24'h000001, '0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 4;
            case (ph % 3)
                0: rad = '0;
                1: rad = RADW'($urandom_range(0, 23'h00FFFF));
                default: rad = RADW'($urandom);
            endcase
            set_shell(CW'($urandom), CW'($urandom), CW'($urandom), rad,
                      (ph == 6) ? 32'h8000_0000 : (ph == 7) ? 32'h7FFF_FFFF : $urandom);
            random_phase(25);
            drain();
            random_phase(25);
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $error("%0d results never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
